// ===== rtl/slcf_pkg.sv =====
// Shared constants and types of the serial LED command frame parser.
`default_nettype none
package slcf_pkg;

  localparam logic [7:0]  CMD_SWITCH   = 8'h01;
  localparam logic [7:0]  CMD_LEVEL    = 8'h02;
  localparam logic [7:0]  ARG_OFF      = 8'h00;
  localparam logic [7:0]  ARG_ON       = 8'h01;
  localparam logic [7:0]  ARG_TOGGLE   = 8'h02;

  localparam logic [7:0]  HDR1_RESET   = 8'hAA;
  localparam logic [7:0]  HDR2_RESET   = 8'h55;
  localparam logic [15:0] SCALE_RESET  = 16'd500;
  localparam logic [15:0] BRIGHT_RESET = 16'd500;
  localparam logic [15:0] LEVEL_MAX    = 16'hFFFF;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_HEADER  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_HEADER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE    = 2'd2;

  // Registered product and shift plan of the float-to-level conversion.
  typedef struct packed {
    logic [39:0] prod;
    logic        force_zero;
    logic        force_max;
    logic        big_left;
    logic        left;
    logic [5:0]  amt;
  } slcf_level_t;

endpackage
`default_nettype wire

// ===== rtl/slcf_level_mul.sv =====
// Multiply stage of the float-to-level conversion: significand times scale.
`default_nettype none
module slcf_level_mul (
  input  logic                 clk,
  input  logic [31:0]          payload,
  input  logic [15:0]          scale,
  output slcf_pkg::slcf_level_t level_op
);
  import slcf_pkg::*;

  logic        sign;
  logic [7:0]  expo;
  logic [22:0] mant;
  logic        denorm;
  logic        max_expo;
  logic [23:0] sig;
  logic [7:0]  expo_eff;
  logic        left;
  logic [7:0]  lamt;
  logic [7:0]  ramt;

  always_comb begin
    sign     = payload[31];
    expo     = payload[30:23];
    mant     = payload[22:0];
    denorm   = (expo == 8'd0);
    max_expo = (expo == 8'hFF);
    sig      = {~denorm, mant};
    expo_eff = denorm ? 8'd1 : expo;
    left     = (expo_eff >= 8'd150);
    lamt     = expo_eff - 8'd150;
    ramt     = 8'd150 - expo_eff;
  end

  always_ff @(posedge clk) begin
    level_op.prod       <= {16'd0, sig} * {24'd0, scale};
    level_op.force_zero <= sign | (max_expo & ((mant != 23'd0) | (scale == 16'd0)))
                           | (~left & (ramt >= 8'd40));
    level_op.force_max  <= ~sign & max_expo & (mant == 23'd0) & (scale != 16'd0);
    level_op.big_left   <= left & (lamt >= 8'd16);
    level_op.left       <= left;
    level_op.amt        <= left ? lamt[5:0] : ramt[5:0];
  end

endmodule
`default_nettype wire

// ===== rtl/slcf_level_sat.sv =====
// Shift and saturate stage of the float-to-level conversion.
`default_nettype none
module slcf_level_sat (
  input  slcf_pkg::slcf_level_t level_op,
  output logic [15:0]           level
);
  import slcf_pkg::*;

  logic [54:0] wide;
  logic [39:0] narrow;

  always_comb begin
    wide   = {15'd0, level_op.prod} << level_op.amt[3:0];
    narrow = level_op.prod >> level_op.amt;
    priority if (level_op.force_zero) begin
      level = 16'd0;
    end else if (level_op.force_max) begin
      level = LEVEL_MAX;
    end else if (level_op.prod == 40'd0) begin
      level = 16'd0;
    end else if (level_op.big_left) begin
      level = LEVEL_MAX;
    end else if (level_op.left) begin
      level = (|wide[54:16]) ? LEVEL_MAX : wide[15:0];
    end else begin
      level = (|narrow[39:16]) ? LEVEL_MAX : narrow[15:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/serial_led_command_frame_parser.sv =====
// Top level of the serial LED command frame parser.
`default_nettype none
// Parses received bytes, one byte per handshake, as frames of first header,
// second header, command, payload and checksum (low byte of the sum of all
// earlier frame bytes). Command 1 carries one byte (0 off, 1 on at the stored
// brightness, 2 toggle); command 2 carries a little-endian single-precision
// value that becomes a brightness of trunc(value * full_scale), saturated to
// 0..65535, with negative values and NaN giving 0. Every accepted byte yields
// exactly one registered result word, showing the compare value, the LED flag
// and whether this byte closed a good or a bad frame. A new byte is taken every
// cycle while the result register is free or being drained; the float product
// is formed in a register stage tracking the payload as it fills, so the checksum
// byte only shifts and saturates it. The user must write the header registers and
// scale through the cfg port only while no byte is in flight; the block does not enforce it.
module serial_led_command_frame_parser (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [slcf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slcf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           byte_valid,
  output logic                           byte_stall,
  input  logic [7:0]                     rx_byte,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [15:0]                    pwm_compare,
  output logic                           led_on,
  output logic                           frame_accepted,
  output logic                           checksum_failed
);
  import slcf_pkg::*;

  localparam logic [2:0] POS_HDR1 = 3'd0;
  localparam logic [2:0] POS_HDR2 = 3'd1;
  localparam logic [2:0] POS_CMD  = 3'd2;
  localparam logic [2:0] POS_PAY0 = 3'd3;
  localparam logic [2:0] POS_CHK1 = 3'd4;
  localparam logic [2:0] POS_CHK4 = 3'd7;

  // Configuration registers.
  logic [7:0]  first_header;
  logic [7:0]  second_header;
  logic [15:0] full_scale;
  logic [15:0] full_scale_next;

  // Parser state.
  logic [2:0]  frame_position,    frame_position_next;
  logic [7:0]  running_sum,       running_sum_next;
  logic        is_float,          is_float_next;
  logic [31:0] payload,           payload_next;
  logic [15:0] stored_brightness, stored_brightness_next;
  logic        led_flag,          led_flag_next;
  logic [15:0] compare_value,     compare_value_next;
  logic        accepted_next;
  logic        failed_next;

  logic        take;
  logic [2:0]  chk_slot;
  logic [1:0]  pay_idx;
  logic [7:0]  sum_add;
  logic [15:0] level;
  slcf_level_t level_op;

  // Hold the byte while a finished result waits to be taken.
  assign byte_stall = result_valid & result_stall;
  assign take       = byte_valid & ~byte_stall;

  assign full_scale_next = (cfg_we && cfg_index == REG_FULL_SCALE) ? cfg_data : full_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_header  <= HDR1_RESET;
      second_header <= HDR2_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FIRST_HEADER:  first_header  <= cfg_data[7:0];
        REG_SECOND_HEADER: second_header <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      full_scale <= SCALE_RESET;
    end else begin
      full_scale <= full_scale_next;
    end
  end

  // The product stage sees the next payload and scale, so its register always
  // matches the current ones.
  slcf_level_mul u_mul (
    .clk      (clk),
    .payload  (payload_next),
    .scale    (full_scale_next),
    .level_op (level_op)
  );

  slcf_level_sat u_sat (
    .level_op (level_op),
    .level    (level)
  );

  always_comb begin
    frame_position_next    = frame_position;
    running_sum_next       = running_sum;
    is_float_next          = is_float;
    payload_next           = payload;
    stored_brightness_next = stored_brightness;
    led_flag_next          = led_flag;
    compare_value_next     = compare_value;
    accepted_next          = 1'b0;
    failed_next            = 1'b0;
    chk_slot               = is_float ? POS_CHK4 : POS_CHK1;
    pay_idx                = frame_position[1:0] - POS_PAY0[1:0];
    sum_add                = running_sum + rx_byte;

    if (take) begin
      unique case (frame_position)
        POS_HDR1: begin
          if (rx_byte == first_header) begin
            running_sum_next    = rx_byte;
            frame_position_next = POS_HDR2;
          end
        end
        POS_HDR2: begin
          // Second header wins; a repeated first header restarts the frame.
          priority if (rx_byte == second_header) begin
            running_sum_next    = sum_add;
            frame_position_next = POS_CMD;
          end else if (rx_byte == first_header) begin
            running_sum_next    = rx_byte;
            frame_position_next = POS_HDR2;
          end else begin
            running_sum_next    = 8'd0;
            frame_position_next = POS_HDR1;
          end
        end
        POS_CMD: begin
          if (rx_byte == CMD_SWITCH || rx_byte == CMD_LEVEL) begin
            running_sum_next    = sum_add;
            is_float_next       = (rx_byte == CMD_LEVEL);
            payload_next        = 32'd0;
            frame_position_next = POS_PAY0;
          end else begin
            running_sum_next    = 8'd0;
            frame_position_next = POS_HDR1;
          end
        end
        default: begin
          if (frame_position < chk_slot) begin
            // Collect payload, first byte in the low lane.
            unique case (pay_idx)
              2'd0: payload_next[7:0]   = rx_byte;
              2'd1: payload_next[15:8]  = rx_byte;
              2'd2: payload_next[23:16] = rx_byte;
              default: payload_next[31:24] = rx_byte;
            endcase
            running_sum_next    = sum_add;
            frame_position_next = frame_position + 3'd1;
          end else begin
            if (rx_byte == running_sum) begin
              accepted_next = 1'b1;
              if (is_float) begin
                stored_brightness_next = level;
                compare_value_next     = level;
              end else begin
                unique case (payload[7:0])
                  ARG_OFF: begin
                    compare_value_next = 16'd0;
                    led_flag_next      = 1'b0;
                  end
                  ARG_ON: begin
                    compare_value_next = stored_brightness;
                    led_flag_next      = 1'b1;
                  end
                  ARG_TOGGLE: begin
                    compare_value_next = led_flag ? 16'd0 : stored_brightness;
                    led_flag_next      = ~led_flag;
                  end
                  default: ;
                endcase
              end
            end else begin
              failed_next = 1'b1;
            end
            frame_position_next = POS_HDR1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position    <= POS_HDR1;
      running_sum       <= 8'd0;
      is_float          <= 1'b0;
      payload           <= 32'd0;
      stored_brightness <= BRIGHT_RESET;
      led_flag          <= 1'b0;
      compare_value     <= 16'd0;
    end else begin
      frame_position    <= frame_position_next;
      running_sum       <= running_sum_next;
      is_float          <= is_float_next;
      payload           <= payload_next;
      stored_brightness <= stored_brightness_next;
      led_flag          <= led_flag_next;
      compare_value     <= compare_value_next;
    end
  end

  // Result register: load on every taken byte, drop valid once drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      pwm_compare     <= compare_value_next;
      led_on          <= led_flag_next;
      frame_accepted  <= accepted_next;
      checksum_failed <= failed_next;
    end
  end

`ifndef SYNTHESIS
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(frame_accepted && checksum_failed))
    else $error("frame_accepted and checksum_failed both set");

  a_take_gives_result: assert property (@(posedge clk) disable iff (rst)
    take |=> result_valid)
    else $error("taken byte produced no result");

  a_switch_frame_short: assert property (@(posedge clk) disable iff (rst)
    !is_float |-> (frame_position <= POS_CHK1))
    else $error("switch frame ran past its checksum position");
`endif

endmodule
`default_nettype wire
